// File: design/ypd_pkg.sv
// Shared constants for the yaw PD controller with angle wrap and rate clamp.
package ypd_pkg;

    // Angle constants in Q3.12 radians, and milliseconds per second.
    localparam logic signed [16:0] PI_Q12     = 17'sd12868;
    localparam logic signed [16:0] TWO_PI_Q12 = 17'sd25736;
    localparam logic signed [16:0] MS_PER_S   = 17'sd1000;

    // Register reset values.
    localparam logic [15:0] KP_RESET    = 16'd768;
    localparam logic [15:0] KD_RESET    = 16'd77;
    localparam logic [14:0] LIMIT_RESET = 15'd410;

    // Configuration register indexes (byte address is 4 times the index).
    typedef enum logic [1:0] {
        REG_KP    = 2'd0,
        REG_KD    = 2'd1,
        REG_LIMIT = 2'd2,
        REG_NONE  = 2'd3
    } reg_index_t;

    // Width of the quotient magnitude; the scaled error difference stays below 2^25.
    localparam int QUO_W = 25;

endpackage

// File: design/yaw_pd_wrap_rate_limited.sv
// Yaw PD controller top level: sequencer, shared multiplier and serial divider.

// One transaction takes a measured and a target yaw angle with a millisecond time stamp and
// returns one yaw rate command. When the time stamp equals the one of the last computed
// command, that command is repeated with held set: the transaction goes straight to the done
// state, which, once the output register is free, loads it and makes the input ready again.
// Any other transaction passes through the error-difference, divider set-up, division,
// derivative-multiply and sum states before the done state: one shared 27x17 multiplier
// forms the scaled error difference, the proportional term and the derivative term in turn,
// and a restoring divider produces the 25-bit derivative magnitude one bit per cycle.
// The input is not ready while a transaction is in work; a finished result waits in the
// output register, so a new transaction is accepted while the previous result is still
// pending; a stalled result channel holds the next result in the done state, input busy.
module yaw_pd_wrap_rate_limited
    import ypd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // Input channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [14:0] s_yaw_measured,
    input  logic signed [14:0] s_yaw_target,
    input  logic [31:0]        s_stamp_ms,
    // Result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_yaw_rate_cmd,
    output logic               m_held
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DNUM,
        S_DIVSET,
        S_DIV,
        S_MULD,
        S_SUM,
        S_DONE
    } state_t;

    state_t state_reg;

    logic [15:0]        kp_reg;
    logic [15:0]        kd_reg;
    logic [14:0]        limit_reg;

    logic [31:0]        prev_stamp_reg;
    logic signed [14:0] prev_err_reg;
    logic signed [15:0] last_cmd_reg;

    logic [31:0]        stamp_reg;
    logic [31:0]        elapsed_reg;
    logic signed [14:0] err_reg;
    logic               held_reg;
    logic signed [42:0] prod_reg;
    logic signed [30:0] acc_reg;
    logic [QUO_W-1:0]   quo_reg;
    logic [QUO_W-1:0]   rem_reg;
    logic               neg_reg;
    logic [4:0]         cnt_reg;
    logic signed [15:0] cmd_reg;

    logic               m_valid_reg;
    logic signed [15:0] m_cmd_reg;
    logic               m_held_reg;

    logic               s_accept;
    logic               cfg_write;
    reg_index_t         cfg_index;

    // Error wrap on the incoming angles.
    logic signed [16:0] err_raw;
    logic signed [16:0] err_wrap;

    // Shared multiplier.
    logic signed [26:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [43:0] mul_p;

    logic signed [15:0] err_diff;
    logic signed [25:0] dnum;
    logic signed [25:0] dnum_mag;
    logic signed [25:0] deriv;

    // Divider step.
    logic [QUO_W:0]     div_shift;
    logic [31:0]        div_cmp;
    logic [31:0]        div_sub;
    logic               div_ge;

    // Final sum and clamp.
    logic signed [42:0] sum;
    logic signed [34:0] sum_shr;
    logic signed [34:0] lim_pos;
    logic signed [34:0] lim_neg;
    logic signed [34:0] clamped;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = reg_index_t'(paddr[3:2]);

    always_comb begin
        unique case (cfg_index)
            REG_KP:    prdata = {16'd0, kp_reg};
            REG_KD:    prdata = {16'd0, kd_reg};
            REG_LIMIT: prdata = {17'd0, limit_reg};
            default:   prdata = 32'd0;
        endcase
    end

    assign s_ready  = (state_reg == S_IDLE);
    assign s_accept = s_valid && s_ready;

    assign m_valid        = m_valid_reg;
    assign m_yaw_rate_cmd = m_cmd_reg;
    assign m_held         = m_held_reg;

    always_comb begin
        err_raw = 17'(s_yaw_target) - 17'(s_yaw_measured);
        priority if (err_raw > PI_Q12) begin
            err_wrap = err_raw - TWO_PI_Q12;
        end else if (err_raw < -PI_Q12) begin
            err_wrap = err_raw + TWO_PI_Q12;
        end else begin
            err_wrap = err_raw;
        end
    end

    assign err_diff = 16'(err_reg) - 16'(prev_err_reg);
    assign dnum     = prod_reg[25:0];
    assign dnum_mag = dnum[25] ? -dnum : dnum;
    assign deriv    = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

    always_comb begin
        unique case (state_reg)
            S_DNUM: begin
                mul_a = 27'(err_diff);
                mul_b = MS_PER_S;
            end
            S_DIVSET: begin
                mul_a = 27'(err_reg);
                mul_b = $signed({1'b0, kp_reg});
            end
            S_MULD: begin
                mul_a = 27'(deriv);
                mul_b = $signed({1'b0, kd_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // One restoring step: the partial remainder never reaches 2^25.
    assign div_shift = {rem_reg, quo_reg[QUO_W-1]};
    assign div_cmp   = {6'd0, div_shift};
    assign div_ge    = (div_cmp >= elapsed_reg);
    assign div_sub   = div_cmp - elapsed_reg;

    assign sum     = 43'(acc_reg) + prod_reg;
    assign sum_shr = sum[42:8];
    assign lim_pos = $signed({20'd0, limit_reg});
    assign lim_neg = -lim_pos;

    always_comb begin
        priority if (sum_shr > lim_pos) begin
            clamped = lim_pos;
        end else if (sum_shr < lim_neg) begin
            clamped = lim_neg;
        end else begin
            clamped = sum_shr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            kp_reg         <= KP_RESET;
            kd_reg         <= KD_RESET;
            limit_reg      <= LIMIT_RESET;
            prev_stamp_reg <= '0;
            prev_err_reg   <= '0;
            last_cmd_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_write) begin
                unique case (cfg_index)
                    REG_KP:    kp_reg    <= pwdata[15:0];
                    REG_KD:    kd_reg    <= pwdata[15:0];
                    REG_LIMIT: limit_reg <= pwdata[14:0];
                    default:   ;
                endcase
            end

            // In the done state the output register is reloaded instead.
            if (m_valid_reg && m_ready && (state_reg != S_DONE)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        stamp_reg   <= s_stamp_ms;
                        elapsed_reg <= s_stamp_ms - prev_stamp_reg;
                        err_reg     <= err_wrap[14:0];
                        held_reg    <= (s_stamp_ms == prev_stamp_reg);
                        cmd_reg     <= last_cmd_reg;
                        state_reg   <= (s_stamp_ms == prev_stamp_reg) ? S_DONE : S_DNUM;
                    end
                end
                S_DNUM: begin
                    prod_reg  <= mul_p[42:0];
                    state_reg <= S_DIVSET;
                end
                S_DIVSET: begin
                    quo_reg   <= dnum_mag[QUO_W-1:0];
                    neg_reg   <= dnum[25];
                    rem_reg   <= '0;
                    cnt_reg   <= 5'(QUO_W - 1);
                    prod_reg  <= mul_p[42:0];
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    // The proportional term sits in prod_reg for the whole division.
                    acc_reg <= prod_reg[30:0];
                    rem_reg <= div_ge ? div_sub[QUO_W-1:0] : div_shift[QUO_W-1:0];
                    quo_reg <= {quo_reg[QUO_W-2:0], div_ge};
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0) begin
                        state_reg <= S_MULD;
                    end
                end
                S_MULD: begin
                    prod_reg  <= mul_p[42:0];
                    state_reg <= S_SUM;
                end
                S_SUM: begin
                    cmd_reg   <= clamped[15:0];
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_cmd_reg   <= cmd_reg;
                        m_held_reg  <= held_reg;
                        if (!held_reg) begin
                            prev_stamp_reg <= stamp_reg;
                            prev_err_reg   <= err_reg;
                            last_cmd_reg   <= cmd_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    // A held result always repeats the stored command.
    a_held_repeats: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_held_reg) |-> (m_cmd_reg == last_cmd_reg))
        else $error("held result differs from the stored command");

    // A computed result stays inside the rate limit.
    a_cmd_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_held_reg) |->
            ($signed(17'(m_cmd_reg)) <= $signed({2'b00, limit_reg}) &&
             $signed(17'(m_cmd_reg)) >= -$signed({2'b00, limit_reg})))
        else $error("computed command outside the rate limit");

    // The partial remainder stays below the divisor throughout the division.
    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> ({7'd0, rem_reg} < elapsed_reg))
        else $error("divider remainder not below the elapsed time");

    // An accepted transaction always starts work and blocks the input.
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_ready)
        else $error("input ready right after an accepted transaction");
`endif

endmodule
